>>> hw/rtl/ansi_text_console_parser_defines.svh
// assertion macros used by the checker file
`ifndef ANSI_TEXT_CONSOLE_PARSER_DEFINES_SVH
`define ANSI_TEXT_CONSOLE_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ACP_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ACP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/acp_pkg.sv
// package with types and constants of the text console parser
package acp_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int SEQ_MAX     = 32;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int SEQ_W = 6;
    localparam int PAR_W = 6;

    localparam logic [ROW_W-1:0] ROWS_END = ROW_W'(SCREEN_ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] COLS_END = COL_W'(SCREEN_COLS);
    localparam logic [SEQ_W-1:0] SEQ_LIMIT = SEQ_W'(SEQ_MAX - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_ESC      = 8'h1B;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_PLUS     = 8'h2B;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_SEMI     = 8'h3B;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_K        = 8'h4B;
    localparam logic [7:0] CHAR_M        = 8'h6D;
    localparam logic [7:0] FINAL_LO      = 8'h40;
    localparam logic [7:0] FINAL_HI      = 8'h7E;

    localparam logic [7:0] COLOR_RESET = 8'h07;

    localparam logic [PAR_W-1:0] SGR_BOLD   = 6'd1;
    localparam logic [PAR_W-1:0] SGR_NORMAL = 6'd22;
    localparam logic [PAR_W-1:0] SGR_FG_LO  = 6'd30;
    localparam logic [PAR_W-1:0] SGR_FG_HI  = 6'd37;
    localparam logic [PAR_W-1:0] SGR_BG_LO  = 6'd40;
    localparam logic [PAR_W-1:0] SGR_BG_HI  = 6'd47;
    localparam logic [PAR_W-1:0] PARAM_SAT  = 6'd63;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_CLEAR,
        KIND_SCROLL
    } kind_t;

    typedef enum logic [1:0] {
        PH_BLANKS,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        kind_t            kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [7:0]       glyph;
        logic [7:0]       color;
        logic             last;
    } cmd_t;

endpackage

>>> hw/rtl/ansi_text_console_parser.sv
// top level of the ansi text console parser
// Takes one byte per cycle while in_ready is high. Each accepted byte lands in an input register
// and is decoded from there, once the queue has room, into zero, one or two screen commands, which
// go into a four-entry output queue and show on the outputs from its registers. A
// byte is decoded only while the queue has room for two commands, so input stalls only when
// the consumer leaves more than two commands waiting; a plain byte other than LF arriving with the
// cursor below the screen yields a scroll command followed by a write command.
module ansi_text_console_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] command_kind,
    output logic [4:0] row,
    output logic [6:0] column,
    output logic [7:0] glyph,
    output logic [7:0] color,
    output logic       last
);
    import acp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       proc_fire;
    logic       has_room;
    logic       not_empty;
    logic [1:0] cmd_count;
    logic [1:0] push_count;
    cmd_t       cmd0;
    cmd_t       cmd1;
    cmd_t       head;

    assign proc_fire     = in_valid_reg && has_room;
    assign in_ready      = !in_valid_reg || proc_fire;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;
    assign push_count    = proc_fire ? cmd_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
        end
    end

    acp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .data      (byte_reg),
        .cmd0      (cmd0),
        .cmd1      (cmd1),
        .cmd_count (cmd_count)
    );

    acp_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .cmd0       (cmd0),
        .cmd1       (cmd1),
        .pop        (out_valid && out_ready),
        .head       (head),
        .not_empty  (not_empty),
        .has_room   (has_room)
    );

    assign out_valid    = not_empty;
    assign command_kind = head.kind;
    assign row          = head.row;
    assign column       = head.column;
    assign glyph        = head.glyph;
    assign color        = head.color;
    assign last         = head.last;

endmodule

>>> hw/rtl/acp_core.sv
// cursor, color and escape sequence state, one input byte per cycle while fire is high
module acp_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    data,
    output acp_pkg::cmd_t cmd0,
    output acp_pkg::cmd_t cmd1,
    output logic [1:0]    cmd_count
);
    import acp_pkg::*;

    logic [ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [7:0]       text_color_reg, text_color_next;
    logic [SEQ_W-1:0] seq_length_reg, seq_length_next;
    logic [7:0]       shadow_color_reg, shadow_color_next;
    logic [PAR_W-1:0] param_value_reg, param_value_next;
    phase_t           param_phase_reg, param_phase_next;
    logic             param_negative_reg, param_negative_next;

    // vga palette order
    function automatic logic [2:0] palette(input logic [2:0] idx);
        logic [2:0] res;
        case (idx)
            3'd0: res = 3'd0;
            3'd1: res = 3'd4;
            3'd2: res = 3'd2;
            3'd3: res = 3'd6;
            3'd4: res = 3'd1;
            3'd5: res = 3'd5;
            3'd6: res = 3'd3;
            default: res = 3'd7;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] sgr_apply(input logic [7:0] c,
                                             input logic [PAR_W-1:0] v,
                                             input logic neg);
        logic [3:0]       fg;
        logic [3:0]       bg;
        logic [PAR_W-1:0] off_fg;
        logic [PAR_W-1:0] off_bg;
        fg     = c[3:0];
        bg     = c[7:4];
        off_fg = v - SGR_FG_LO;
        off_bg = v - SGR_BG_LO;
        if (!neg)
        begin
            if (v >= SGR_FG_LO && v <= SGR_FG_HI)
            begin
                fg = {fg[3], palette(off_fg[2:0])};
            end
            else if (v >= SGR_BG_LO && v <= SGR_BG_HI)
            begin
                bg = {1'b0, palette(off_bg[2:0])};
            end
            else if (v == SGR_BOLD)
            begin
                fg[3] = 1'b1;
            end
            else if (v == SGR_NORMAL)
            begin
                fg[3] = 1'b0;
            end
        end
        return {bg, fg};
    endfunction

    logic             is_blank;
    logic             is_digit;
    logic             is_final;
    logic [9:0]       acc;
    logic [ROW_W-1:0] row_v;
    logic [COL_W-1:0] col_v;
    logic             scrolled;
    cmd_t             scroll_cmd;
    cmd_t             write_cmd;

    assign is_blank = (data == CHAR_SPACE) || (data >= CHAR_TAB && data <= CHAR_CR);
    assign is_digit = (data >= CHAR_ZERO) && (data <= CHAR_NINE);
    assign is_final = (data >= FINAL_LO) && (data <= FINAL_HI);
    assign acc      = {4'b0, param_value_reg} * 10'd10 + {6'b0, data[3:0]};

    always_comb
    begin
        cursor_row_next     = cursor_row_reg;
        cursor_col_next     = cursor_col_reg;
        text_color_next     = text_color_reg;
        seq_length_next     = seq_length_reg;
        shadow_color_next   = shadow_color_reg;
        param_value_next    = param_value_reg;
        param_phase_next    = param_phase_reg;
        param_negative_next = param_negative_reg;
        cmd0                = '0;
        cmd1                = '0;
        cmd_count           = 2'd0;
        row_v               = cursor_row_reg;
        col_v               = cursor_col_reg;
        scrolled            = 1'b0;
        scroll_cmd          = '{KIND_SCROLL, LAST_ROW, '0, CHAR_SPACE, text_color_reg, 1'b0};
        write_cmd           = '0;

        if (!fire)
        begin
            cmd_count = 2'd0;
        end
        else if (data == CHAR_ESC)
        begin
            seq_length_next = SEQ_W'(1);
        end
        else if (seq_length_reg != '0)
        begin
            if (seq_length_reg == SEQ_W'(1))
            begin
                if (data == CHAR_LBRACKET)
                begin
                    seq_length_next     = SEQ_W'(2);
                    shadow_color_next   = text_color_reg;
                    param_value_next    = '0;
                    param_phase_next    = PH_BLANKS;
                    param_negative_next = 1'b0;
                end
                else
                begin
                    seq_length_next = '0;
                end
            end
            else if (is_final)
            begin
                seq_length_next = '0;
                if (data == CHAR_K)
                begin
                    if (cursor_row_reg != ROWS_END)
                    begin
                        cmd0 = '{KIND_CLEAR, cursor_row_reg, cursor_col_reg, CHAR_SPACE,
                                 text_color_reg, 1'b1};
                        cmd_count       = 2'd1;
                        cursor_row_next = cursor_row_reg + ROW_W'(1);
                        cursor_col_next = '0;
                    end
                end
                else if (data == CHAR_M)
                begin
                    shadow_color_next = sgr_apply(shadow_color_reg, param_value_reg,
                                                  param_negative_reg);
                    text_color_next   = shadow_color_next;
                end
            end
            else if (seq_length_reg >= SEQ_LIMIT)
            begin
                seq_length_next = '0;
            end
            else
            begin
                seq_length_next = seq_length_reg + SEQ_W'(1);
                if (data == CHAR_SEMI)
                begin
                    shadow_color_next   = sgr_apply(shadow_color_reg, param_value_reg,
                                                    param_negative_reg);
                    param_value_next    = '0;
                    param_phase_next    = PH_BLANKS;
                    param_negative_next = 1'b0;
                end
                else if (param_phase_reg == PH_BLANKS && is_blank)
                begin
                    param_phase_next = PH_BLANKS;
                end
                else if (param_phase_reg == PH_BLANKS &&
                         (data == CHAR_PLUS || data == CHAR_MINUS))
                begin
                    param_negative_next = (data == CHAR_MINUS);
                    param_phase_next    = PH_DIGITS;
                end
                else if (param_phase_reg == PH_BLANKS || param_phase_reg == PH_DIGITS)
                begin
                    if (is_digit)
                    begin
                        param_phase_next = PH_DIGITS;
                        param_value_next = (acc > 10'(PARAM_SAT)) ? PARAM_SAT : acc[PAR_W-1:0];
                    end
                    else
                    begin
                        param_phase_next = PH_DONE;
                    end
                end
            end
        end
        else
        begin
            // lazy scroll when the cursor sits below the screen
            if (cursor_row_reg >= ROWS_END)
            begin
                scrolled = 1'b1;
                row_v    = LAST_ROW;
                col_v    = '0;
            end
            write_cmd = '{KIND_WRITE, row_v, col_v, data, text_color_reg, 1'b1};
            if (data == CHAR_LF)
            begin
                col_v = '0;
                row_v = row_v + ROW_W'(1);
            end
            else
            begin
                col_v = col_v + COL_W'(1);
                if (col_v >= COLS_END)
                begin
                    col_v = '0;
                    row_v = row_v + ROW_W'(1);
                end
            end
            cursor_row_next = row_v;
            cursor_col_next = col_v;

            if (scrolled && data != CHAR_LF)
            begin
                cmd0      = scroll_cmd;
                cmd1      = write_cmd;
                cmd_count = 2'd2;
            end
            else if (scrolled)
            begin
                cmd0      = scroll_cmd;
                cmd0.last = 1'b1;
                cmd_count = 2'd1;
            end
            else if (data != CHAR_LF)
            begin
                cmd0      = write_cmd;
                cmd_count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg     <= '0;
            cursor_col_reg     <= '0;
            text_color_reg     <= COLOR_RESET;
            seq_length_reg     <= '0;
            shadow_color_reg   <= COLOR_RESET;
            param_value_reg    <= '0;
            param_phase_reg    <= PH_BLANKS;
            param_negative_reg <= 1'b0;
        end
        else
        begin
            cursor_row_reg     <= cursor_row_next;
            cursor_col_reg     <= cursor_col_next;
            text_color_reg     <= text_color_next;
            seq_length_reg     <= seq_length_next;
            shadow_color_reg   <= shadow_color_next;
            param_value_reg    <= param_value_next;
            param_phase_reg    <= param_phase_next;
            param_negative_reg <= param_negative_next;
        end
    end

endmodule

>>> hw/rtl/acp_out_queue.sv
// four-entry command queue that takes up to two commands a cycle
module acp_out_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  acp_pkg::cmd_t cmd0,
    input  acp_pkg::cmd_t cmd1,
    input  logic          pop,
    output acp_pkg::cmd_t head,
    output logic          not_empty,
    output logic          has_room
);
    import acp_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_plus;

    assign wr_ptr_plus = wr_ptr_reg + QPTR_W'(1);
    assign head        = entry_reg[rd_ptr_reg];
    assign not_empty   = (count_reg != '0);
    // room for a two-command request
    assign has_room    = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= cmd0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= cmd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/acp_checker.sv
// port-level checker for the ansi text console parser and its bind
`include "ansi_text_console_parser_defines.svh"

module acp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] command_kind,
    input logic [4:0] row,
    input logic [6:0] column,
    input logic [7:0] glyph,
    input logic [7:0] color,
    input logic       last
);
    import acp_pkg::*;

    `ACP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result request dropped")
    `ACP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({command_kind, row, column, glyph, color, last}), "result changed while stalled")
    `ACP_ASSERT(a_scroll_fields, out_valid && command_kind == KIND_SCROLL, row == LAST_ROW && column == '0 && glyph == CHAR_SPACE, "bad scroll command")
    `ACP_ASSERT(a_clear_fields, out_valid && command_kind == KIND_CLEAR, last && glyph == CHAR_SPACE && row < ROWS_END, "bad clear command")
    `ACP_ASSERT(a_write_pos, out_valid && command_kind == KIND_WRITE, last && row < ROWS_END && column < COLS_END, "write outside screen")

endmodule

bind ansi_text_console_parser acp_checker u_acp_checker (.*);
